FILE: sv/ubsm_pkg.sv
// shared types, pattern table and helpers of the url blocklist substring matcher
// no dependencies
`default_nettype none

package ubsm_pkg;

  localparam int unsigned CellCount = 21;
  localparam int unsigned IdxW      = $clog2(CellCount);
  localparam int unsigned PatCount  = 23;
  localparam int unsigned PatBits   = CellCount * 8;

  typedef logic [PatCount-1:0] pat_vec_t;
  typedef logic [IdxW-1:0]     cell_idx_t;

  // per-cycle commands broadcast to every cell of the row
  typedef struct packed {
    logic adv;      // a byte is transferred in
    logic restart;  // component changed, drop partial matches first
    logic flush;    // url ended, clear the row
  } cell_ctrl_t;

  // string literals are right justified: the last character sits in the low byte
  localparam logic [PatBits-1:0] PatText [PatCount] = '{
    PatBits'("googletagmanager.com"),
    PatBits'("google-analytics.com"),
    PatBits'("scorecardresearch.com"),
    PatBits'("adnxs.com"),
    PatBits'("doubleclick.net"),
    PatBits'("amazon-adsystem.com"),
    PatBits'("segment.io"),
    PatBits'("mixpanel.com"),
    PatBits'("hotjar.com"),
    PatBits'("optimizely.com"),
    PatBits'("criteo.com"),
    PatBits'("pubmatic.com"),
    PatBits'("rubiconproject.com"),
    PatBits'("taboola.com"),
    PatBits'("outbrain.com"),
    PatBits'("telemetry"),
    PatBits'("adsystem"),
    PatBits'("adserver"),
    PatBits'("prebid.js"),
    PatBits'("analytics.js"),
    PatBits'("/telemetry/"),
    PatBits'("/adserver/"),
    PatBits'("/ads/")
  };

  localparam cell_idx_t PatLen [PatCount] = '{
    IdxW'(20), IdxW'(20), IdxW'(21), IdxW'(9),  IdxW'(15), IdxW'(19),
    IdxW'(10), IdxW'(12), IdxW'(10), IdxW'(14), IdxW'(10), IdxW'(12),
    IdxW'(18), IdxW'(11), IdxW'(12), IdxW'(9),  IdxW'(8),  IdxW'(8),
    IdxW'(9),  IdxW'(12), IdxW'(11), IdxW'(10), IdxW'(5)
  };

  // set where the pattern applies to the path component
  localparam pat_vec_t PathMask = pat_vec_t'(23'b11111_000000000000000000);

  // character j (counted from the start) of pattern k, zero past its end
  function automatic logic [7:0] pat_char(input int unsigned k, input cell_idx_t j);
    cell_idx_t pos;
    logic [7:0] ch;
    ch = 8'd0;
    if (j < PatLen[k]) begin
      pos = PatLen[k] - j - IdxW'(1);
      ch  = PatText[k][pos*8 +: 8];
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

FILE: sv/url_blocklist_substring_matcher.sv
// Takes one byte of a URL's host or path component per cycle and reports, at the
// end-of-URL item, whether any of 18 host or 5 path blocklist strings occurred as
// a case-sensitive substring of its own component in a URL with a host. A row of
// 21 cells tracks, for every pattern, the prefixes that the latest bytes complete;
// one update of the row per transfer lets a new item be accepted in every cycle.
// The result is in the output register right after the edge that transfers the
// end item in, and the input keeps flowing while that result waits to be taken;
// only the next end item is held back until the output register is free.
// uses ubsm_pkg and ubsm_chain
`default_nettype none

module url_blocklist_substring_matcher (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire [7:0]  data_byte_i,
  input  wire        byte_valid_i,
  input  wire        is_path_i,
  input  wire        end_of_url_i,
  input  wire        has_host_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic       blocked_o,
  output logic       by_path_o
);

  logic in_xfer;
  logic adv;
  logic eou;
  ubsm_pkg::cell_ctrl_t ctrl;
  ubsm_pkg::pat_vec_t   hit;

  logic part_d, part_q;
  logic host_hit_d, host_hit_q;
  logic path_hit_d, path_hit_q;
  logic host_now, path_now;
  logic out_valid_d, out_valid_q;
  logic blocked_d, blocked_q;
  logic by_path_d, by_path_q;

  // only an end item needs room in the output register
  assign in_ready_o = !out_valid_q || out_ready_i || !end_of_url_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign adv        = in_xfer && byte_valid_i;
  assign eou        = in_xfer && end_of_url_i;

  assign ctrl.adv     = adv;
  assign ctrl.restart = adv && (is_path_i != part_q);
  assign ctrl.flush   = eou;

  ubsm_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .byte_i (data_byte_i),
    .hit_o  (hit)
  );

  // only patterns of the byte's own component count
  assign host_now = adv && !is_path_i && |(hit & ~ubsm_pkg::PathMask);
  assign path_now = adv &&  is_path_i && |(hit &  ubsm_pkg::PathMask);

  always_comb begin
    part_d      = part_q;
    host_hit_d  = host_hit_q || host_now;
    path_hit_d  = path_hit_q || path_now;
    out_valid_d = out_valid_q && !out_ready_i;
    blocked_d   = blocked_q;
    by_path_d   = by_path_q;
    if (adv) begin
      part_d = is_path_i;
    end
    if (eou) begin
      out_valid_d = 1'b1;
      blocked_d   = has_host_i && (host_hit_d || path_hit_d);
      by_path_d   = has_host_i && !host_hit_d && path_hit_d;
      part_d      = 1'b0;
      host_hit_d  = 1'b0;
      path_hit_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q      <= 1'b0;
      host_hit_q  <= 1'b0;
      path_hit_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      part_q      <= part_d;
      host_hit_q  <= host_hit_d;
      path_hit_q  <= path_hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blocked_q <= blocked_d;
    by_path_q <= by_path_d;
  end

  assign out_valid_o = out_valid_q;
  assign blocked_o   = blocked_q;
  assign by_path_o   = by_path_q;

  // an end-of-url transfer always leaves a result in the output register
  a_result_follows_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    eou |=> out_valid_o)
    else $error("no result after end-of-url transfer");

  // a path-only decision is always a block
  a_by_path_implies_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && by_path_o |-> blocked_o)
    else $error("by_path set without blocked");

  // the url state starts over after every end-of-url transfer
  a_state_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    eou |=> !host_hit_q && !path_hit_q && !part_q)
    else $error("url state not cleared after end");

endmodule

`default_nettype wire

FILE: sv/ubsm_cell.sv
// one cell of the match row: holds, for every pattern, whether the bytes seen
// end in that pattern's prefix of length idx+1; uses ubsm_pkg
`default_nettype none

module ubsm_cell (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire ubsm_pkg::cell_idx_t   idx_i,
  input  wire ubsm_pkg::cell_ctrl_t  ctrl_i,
  input  wire logic [7:0]            byte_i,
  input  wire ubsm_pkg::pat_vec_t    prev_i,
  output ubsm_pkg::pat_vec_t         match_o,
  output ubsm_pkg::pat_vec_t         state_o
);

  ubsm_pkg::pat_vec_t eq;
  ubsm_pkg::pat_vec_t state_d, state_q;

  always_comb begin
    for (int unsigned k = 0; k < ubsm_pkg::PatCount; k++) begin
      eq[k] = (idx_i < ubsm_pkg::PatLen[k]) && (byte_i == ubsm_pkg::pat_char(k, idx_i));
    end
  end

  // a component change drops the prefix handed over by the neighbor,
  // the head cell still starts a new prefix with the first byte
  assign match_o = ((ctrl_i.restart && (idx_i != '0)) ? '0 : prev_i) & eq;

  always_comb begin
    state_d = state_q;
    if (ctrl_i.flush) begin
      state_d = '0;
    end else if (ctrl_i.adv) begin
      state_d = match_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

`default_nettype wire

FILE: sv/ubsm_chain.sv
// row of match cells, each passing its prefix state to the next one;
// gathers the full-length hits per pattern; uses ubsm_pkg and ubsm_cell
`default_nettype none

module ubsm_chain (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire ubsm_pkg::cell_ctrl_t  ctrl_i,
  input  wire logic [7:0]            byte_i,
  output ubsm_pkg::pat_vec_t         hit_o
);

  ubsm_pkg::pat_vec_t match [ubsm_pkg::CellCount];
  ubsm_pkg::pat_vec_t state [ubsm_pkg::CellCount];

  for (genvar j = 0; j < ubsm_pkg::CellCount; j++) begin : g_cell
    ubsm_pkg::pat_vec_t prev;
    if (j == 0) begin : g_head
      assign prev = '1;
    end else begin : g_body
      assign prev = state[j-1];
    end

    ubsm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (ubsm_pkg::cell_idx_t'(j)),
      .ctrl_i  (ctrl_i),
      .byte_i  (byte_i),
      .prev_i  (prev),
      .match_o (match[j]),
      .state_o (state[j])
    );
  end

  // a pattern hits when the cell at its last character completes the prefix
  for (genvar k = 0; k < ubsm_pkg::PatCount; k++) begin : g_hit
    assign hit_o[k] = match[ubsm_pkg::PatLen[k] - 1][k];
  end

endmodule

`default_nettype wire

FILE: dv/tb_url_blocklist_substring_matcher.sv
// self-checking testbench for url_blocklist_substring_matcher: drives random urls built
// around the blocklist strings and checks every verdict against a local byte-window predictor
// depends on sv/url_blocklist_substring_matcher.sv and the files it pulls in
`default_nettype none

localparam int WIN_BYTES = 21;
localparam int PAT_NUM   = 23;

typedef struct {
  logic [7:0] data;
  bit         bv;
  bit         part;
  bit         eou;
  bit         host;
} url_item_t;

class verdict_board;
  typedef struct packed {
    logic blocked;
    logic by_path;
  } verdict_t;

  string pat_text [PAT_NUM] = '{
    "googletagmanager.com", "google-analytics.com", "scorecardresearch.com", "adnxs.com",
    "doubleclick.net", "amazon-adsystem.com", "segment.io", "mixpanel.com", "hotjar.com",
    "optimizely.com", "criteo.com", "pubmatic.com", "rubiconproject.com", "taboola.com",
    "outbrain.com", "telemetry", "adsystem", "adserver", "prebid.js", "analytics.js",
    "/telemetry/", "/adserver/", "/ads/"
  };
  bit pat_in_path [PAT_NUM] = '{
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 1
  };

  logic [7:0]  win [WIN_BYTES];
  int unsigned run_len;
  bit          cur_part;
  bit          host_hit;
  bit          path_hit;
  verdict_t    verdict_q[$];
  int unsigned errors;

  function new();
    clear_url();
    errors = 0;
  endfunction

  function void clear_window();
    foreach (win[i]) win[i] = 8'h00;
    run_len = 0;
  endfunction

  function void clear_url();
    clear_window();
    cur_part = 1'b0;
    host_hit = 1'b0;
    path_hit = 1'b0;
  endfunction

  // newest byte sits in win[0], so the pattern is compared back to front
  function bit tail_matches(string s);
    int n;
    n = s.len();
    if (n == 0 || n > run_len) return 1'b0;
    for (int k = 0; k < n; k++) begin
      if (win[k] != 8'(s[n - 1 - k])) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void take_item(url_item_t it);
    verdict_t v;
    if (it.bv) begin
      if (it.part != cur_part) begin
        clear_window();
        cur_part = it.part;
      end
      for (int i = WIN_BYTES - 1; i > 0; i--) win[i] = win[i - 1];
      win[0] = it.data;
      if (run_len < WIN_BYTES) run_len++;
      for (int p = 0; p < PAT_NUM; p++) begin
        if (pat_in_path[p] == cur_part && tail_matches(pat_text[p])) begin
          if (cur_part) path_hit = 1'b1;
          else host_hit = 1'b1;
        end
      end
    end
    if (it.eou) begin
      v.blocked = it.host && (host_hit || path_hit);
      v.by_path = it.host && !host_hit && path_hit;
      verdict_q.push_back(v);
      clear_url();
    end
  endfunction

  function void check_verdict(logic blocked, logic by_path);
    verdict_t v;
    if (verdict_q.size() == 0) begin
      $error("unexpected result: blocked=%0b by_path=%0b", blocked, by_path);
      errors++;
      return;
    end
    v = verdict_q.pop_front();
    if (blocked !== v.blocked) begin
      $error("blocked: expected %0b, actual %0b", v.blocked, blocked);
      errors++;
    end
    if (by_path !== v.by_path) begin
      $error("by_path: expected %0b, actual %0b", v.by_path, by_path);
      errors++;
    end
  endfunction

  function int pending();
    return verdict_q.size();
  endfunction
endclass

module tb_url_blocklist_substring_matcher;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 700;
  localparam int URL_TARGET  = 40;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] data_byte_i;
  logic       byte_valid_i;
  logic       is_path_i;
  logic       end_of_url_i;
  logic       has_host_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       blocked_o;
  logic       by_path_o;

  verdict_board board = new();
  url_item_t    url_items[$];
  int           items_sent;
  int           urls_done;
  int           cycle_cnt;
  string        filler_chars = "adegilmnorstbcj.-/_";

  url_blocklist_substring_matcher uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .byte_valid_i (byte_valid_i),
    .is_path_i    (is_path_i),
    .end_of_url_i (end_of_url_i),
    .has_host_i   (has_host_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .blocked_o    (blocked_o),
    .by_path_o    (by_path_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[url_blocklist_substring_matcher] ERROR");
      $finish;
    end
  end

  function automatic void push_item(logic [7:0] data, bit bv, bit part, bit eou, bit host);
    url_item_t it;
    it.data = data;
    it.bv   = bv;
    it.part = part;
    it.eou  = eou;
    it.host = host;
    url_items.push_back(it);
  endfunction

  function automatic void push_text(string s, bit part);
    for (int k = 0; k < s.len(); k++) push_item(8'(s[k]), 1'b1, part, 1'b0, 1'b1);
  endfunction

  // filler bytes around at most one blocklist string, which may be cut short or have one
  // character case-flipped to give near misses
  function automatic void add_component(bit part);
    int         n;
    int         ins_at;
    int         mut;
    int         flip;
    string      pat;
    logic [7:0] ch;
    n = ($urandom_range(0, 7) == 0) ? int'($urandom_range(22, 40)) : int'($urandom_range(0, 12));
    ins_at = ($urandom_range(0, 9) < 6) ? int'($urandom_range(0, n)) : -1;
    for (int i = 0; i <= n; i++) begin
      if (i == ins_at) begin
        pat  = board.pat_text[$urandom_range(0, PAT_NUM - 1)];
        mut  = $urandom_range(0, 9);
        flip = $urandom_range(0, pat.len() - 1);
        for (int k = 0; k < pat.len(); k++) begin
          ch = 8'(pat[k]);
          if (mut >= 8 && k == flip) ch = ch ^ 8'h20;
          if (!(mut == 7 && k == pat.len() - 1))
            push_item(ch, 1'b1, part, 1'b0, 1'($urandom_range(0, 1)));
        end
      end
      if (i < n) begin
        if ($urandom_range(0, 6) == 0) ch = 8'($urandom_range(0, 255));
        else ch = 8'(filler_chars[$urandom_range(0, filler_chars.len() - 1)]);
        push_item(ch, 1'b1, part, 1'b0, 1'($urandom_range(0, 1)));
      end
      // stray marker that carries no byte and no end
      if ($urandom_range(0, 24) == 0)
        push_item(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)), 1'b0,
                  1'($urandom_range(0, 1)));
    end
  endfunction

  task automatic send_item(url_item_t it, bit eager);
    int gap;
    gap = eager ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= it.data;
    byte_valid_i <= it.bv;
    is_path_i    <= it.part;
    end_of_url_i <= it.eou;
    has_host_i   <= it.host;
    do @(posedge clk_i); while (!in_ready_o);
    board.take_item(it);
    items_sent++;
  endtask

  task automatic send_url(bit eager);
    foreach (url_items[i]) send_item(url_items[i], eager);
    url_items.delete();
    urls_done++;
  endtask

  // result side: random stall before each result, with stretches of none
  initial begin : result_sink
    int stall;
    bit eager;
    out_ready_i = 1'b0;
    eager = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) eager = ~eager;
      stall = eager ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      board.check_verdict(blocked_o, by_path_o);
    end
  end

  initial begin : stimulus
    bit eager;
    bit host;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_byte_i  = 8'h00;
    byte_valid_i = 1'b0;
    is_path_i    = 1'b0;
    end_of_url_i = 1'b0;
    has_host_i   = 1'b0;
    items_sent   = 0;
    urls_done    = 0;
    eager        = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bare marker without end does nothing
    push_item(8'hff, 1'b0, 1'b1, 1'b0, 1'b1);
    // host match, but the url has no host
    push_text("adnxs.com", 1'b0);
    url_items[$].eou  = 1'b1;
    url_items[$].host = 1'b0;
    send_url(1'b0);
    // path match followed by a return to host; the hit is kept
    push_text("/ads/", 1'b1);
    push_item(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
    push_item(8'hff, 1'b0, 1'b1, 1'b1, 1'b1);
    send_url(1'b0);
    // zero and all-ones bytes are plain bytes
    push_item(8'h00, 1'b1, 1'b0, 1'b0, 1'b1);
    push_item(8'hff, 1'b1, 1'b1, 1'b1, 1'b1);
    send_url(1'b0);
    // empty url
    push_item(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
    send_url(1'b0);

    while (items_sent < ITEM_TARGET || urls_done < URL_TARGET) begin
      if ($urandom_range(0, 3) == 0) eager = ~eager;
      if ($urandom_range(0, 9) != 0) add_component(1'b0);
      if ($urandom_range(0, 3) != 0) add_component(1'b1);
      if ($urandom_range(0, 9) == 0) add_component(1'b0);
      host = ($urandom_range(0, 4) != 0);
      // end rides on the last byte or on a bare marker
      if (url_items.size() != 0 && url_items[$].bv && $urandom_range(0, 1)) begin
        url_items[$].eou  = 1'b1;
        url_items[$].host = host;
      end else begin
        push_item(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)), 1'b1, host);
      end
      send_url(eager);
    end
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("[url_blocklist_substring_matcher] OK");
    end else begin
      $display("[url_blocklist_substring_matcher] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: url_blocklist_substring_matcher.f
sv/ubsm_pkg.sv
sv/ubsm_cell.sv
sv/ubsm_chain.sv
sv/url_blocklist_substring_matcher.sv
dv/tb_url_blocklist_substring_matcher.sv
